// File: rtl/bounded_back_forward_history_macros.svh
// assertion macros for the bounded back/forward history block
// no dependencies; taken in by the modules that carry assertions
`ifndef BOUNDED_BACK_FORWARD_HISTORY_MACROS_SVH
`define BOUNDED_BACK_FORWARD_HISTORY_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BBFH_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

`define BBFH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`define BBFH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BBFH_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)

`define BBFH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`define BBFH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/bbfh_pkg.sv
// shared types and constants of the bounded back/forward history block
// no dependencies
package bbfh_pkg;

  localparam int STORE_DEPTH    = 128;
  localparam int ADDR_W         = 7;
  localparam int CNT_W          = 7;
  localparam int STORE_USE      = 127;
  localparam int IN_KEY_W       = 32;
  localparam int OUT_KEY_W      = 32;
  localparam int SIDE_LIMIT_DEF = 63;
  localparam int KEY_BITS_DEF   = 32;
  localparam int IN_TDATA_W     = 72;
  localparam int OUT_TDATA_W    = 56;

  typedef enum logic [1:0] {
    CMD_RECORD  = 2'd0,
    CMD_JUMP    = 2'd1,
    CMD_BACK    = 2'd2,
    CMD_FORWARD = 2'd3
  } bbfh_cmd_e;

  typedef struct packed {
    bbfh_cmd_e             cmd;
    logic [IN_KEY_W-1:0]   from_key;
    logic                  from_present;
    logic [IN_KEY_W-1:0]   to_key;
    logic                  to_present;
  } bbfh_item_t;

  typedef struct packed {
    logic                  result_present;
    logic [OUT_KEY_W-1:0]  result_key;
    logic                  can_back;
    logic                  can_forward;
    logic [CNT_W-1:0]      cursor_pos;
    logic [CNT_W-1:0]      entry_count;
  } bbfh_result_t;

endpackage

// File: rtl/bbfh_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module bbfh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bbfh_engine.sv
// command sequencer: read-modify-write of the history ram, cursor, count and ring base
// depends on bbfh_pkg and bounded_back_forward_history_macros.svh
`include "bounded_back_forward_history_macros.svh"

module bbfh_engine #(
  parameter int SIDE_LIMIT = bbfh_pkg::SIDE_LIMIT_DEF,
  parameter int KEY_BITS   = bbfh_pkg::KEY_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  bbfh_pkg::bbfh_item_t        item_i,
  output logic                        ready_o,
  output logic                        done_o,
  input  logic                        out_free_i,
  output bbfh_pkg::bbfh_result_t      result_o,
  output logic                        ram_we_o,
  output logic [bbfh_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [KEY_BITS-1:0]         ram_wdata_o,
  output logic                        ram_re_o,
  output logic [bbfh_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [KEY_BITS-1:0]         ram_rdata_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_REC      = 4'd1;
  localparam logic [3:0] S_RD_CUR   = 4'd2;
  localparam logic [3:0] S_RD_NXT   = 4'd3;
  localparam logic [3:0] S_INS_PREP = 4'd4;
  localparam logic [3:0] S_SHIFT    = 4'd5;
  localparam logic [3:0] S_INS_KEY  = 4'd6;
  localparam logic [3:0] S_TRIM     = 4'd7;
  localparam logic [3:0] S_RES      = 4'd8;
  localparam logic [3:0] S_RES_WAIT = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  localparam logic [8:0]                   SL9  = 9'(SIDE_LIMIT);
  localparam logic [bbfh_pkg::CNT_W-1:0]   FULL = bbfh_pkg::CNT_W'(bbfh_pkg::STORE_USE);
  localparam logic [bbfh_pkg::CNT_W-1:0]   ONE  = bbfh_pkg::CNT_W'(1);

  logic [3:0]                   state_q, state_d;
  bbfh_pkg::bbfh_item_t         item_q, item_d;
  logic                         second_q, second_d;
  logic                         moved_q, moved_d;
  logic [bbfh_pkg::CNT_W-1:0]   cpo_q, cpo_d;
  logic [bbfh_pkg::CNT_W-1:0]   count_q, count_d;
  logic [bbfh_pkg::ADDR_W-1:0]  base_q, base_d;
  logic [bbfh_pkg::ADDR_W-1:0]  idx_q, idx_d;
  logic [bbfh_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic                         pend_q, pend_d;
  logic [bbfh_pkg::ADDR_W-1:0]  pend_log_q, pend_log_d;
  logic [KEY_BITS-1:0]          rkey_q, rkey_d;

  logic [63:0]                  from_ext, to_ext, rkey_ext;
  logic [KEY_BITS-1:0]          key_sel;
  logic                         present_sel;
  logic                         is_rec;

  logic [bbfh_pkg::CNT_W-1:0]   tr_c, tr_c1, tr_extra, tr_cnt1, tr_after, tr_cnt2;
  logic                         tr_front, tr_tail;

  logic [bbfh_pkg::CNT_W-1:0]   ip_cnt, ip_cpo;
  logic [bbfh_pkg::ADDR_W-1:0]  ip_base;

  assign from_ext    = 64'(item_q.from_key);
  assign to_ext      = 64'(item_q.to_key);
  assign key_sel     = second_q ? to_ext[KEY_BITS-1:0] : from_ext[KEY_BITS-1:0];
  assign present_sel = second_q ? item_q.to_present : item_q.from_present;
  assign is_rec      = (item_q.cmd == bbfh_pkg::CMD_RECORD) ||
                       (item_q.cmd == bbfh_pkg::CMD_JUMP);

  // side trimming of the current cursor window
  always_comb begin
    tr_c     = cpo_q - ONE;
    tr_front = (cpo_q != '0) && (9'(tr_c) > SL9);
    tr_extra = tr_front ? (tr_c - SL9[bbfh_pkg::CNT_W-1:0]) : '0;
    tr_c1    = tr_c - tr_extra;
    tr_cnt1  = count_q - tr_extra;
    tr_after = tr_cnt1 - tr_c1 - ONE;
    tr_tail  = (cpo_q != '0) && (9'(tr_after) > SL9);
    tr_cnt2  = tr_tail ? (tr_c1 + ONE + SL9[bbfh_pkg::CNT_W-1:0]) : tr_cnt1;
  end

  // make room when the store is full
  always_comb begin
    ip_cnt  = count_q;
    ip_cpo  = cpo_q;
    ip_base = base_q;
    if (count_q == FULL) begin
      if (cpo_q > ONE) begin
        ip_base = base_q + bbfh_pkg::ADDR_W'(1);
        ip_cpo  = cpo_q - ONE;
      end
      ip_cnt = count_q - ONE;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    second_d    = second_q;
    moved_d     = moved_q;
    cpo_d       = cpo_q;
    count_d     = count_q;
    base_d      = base_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_log_d  = pend_log_q;
    rkey_d      = rkey_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    done_o      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d   = item_i;
          second_d = (item_i.cmd != bbfh_pkg::CMD_JUMP);
          moved_d  = 1'b0;
          state_d  = S_REC;
        end
      end
      S_REC: begin
        case (item_q.cmd)
          bbfh_pkg::CMD_BACK: begin
            if (cpo_q >= bbfh_pkg::CNT_W'(2)) begin
              cpo_d   = cpo_q - ONE;
              moved_d = 1'b1;
              state_d = S_TRIM;
            end else begin
              state_d = S_RES;
            end
          end
          bbfh_pkg::CMD_FORWARD: begin
            if ((cpo_q != '0) && (cpo_q < count_q)) begin
              cpo_d   = cpo_q + ONE;
              moved_d = 1'b1;
              state_d = S_TRIM;
            end else begin
              state_d = S_RES;
            end
          end
          default: begin
            if (!present_sel) begin
              state_d = S_TRIM;
            end else if (cpo_q == '0) begin
              state_d = S_INS_PREP;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = base_q + (cpo_q - ONE);
              state_d     = S_RD_CUR;
            end
          end
        endcase
      end
      S_RD_CUR: begin
        if (ram_rdata_i == key_sel) begin
          state_d = S_TRIM;
        end else if (cpo_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = base_q + cpo_q;
          state_d     = S_RD_NXT;
        end else begin
          state_d = S_INS_PREP;
        end
      end
      S_RD_NXT: begin
        if (ram_rdata_i == key_sel) begin
          cpo_d   = cpo_q + ONE;
          state_d = S_TRIM;
        end else begin
          state_d = S_INS_PREP;
        end
      end
      S_INS_PREP: begin
        count_d = ip_cnt;
        cpo_d   = ip_cpo;
        base_d  = ip_base;
        rem_d   = ip_cnt - ip_cpo;
        idx_d   = ip_cnt - ONE;
        pend_d  = 1'b0;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        // read entry idx, write it one place up in the next cycle
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = base_q + pend_log_q;
          ram_wdata_o = ram_rdata_i;
        end
        if (rem_q != '0) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = base_q + idx_q;
          pend_d      = 1'b1;
          pend_log_d  = idx_q + bbfh_pkg::ADDR_W'(1);
          idx_d       = idx_q - bbfh_pkg::ADDR_W'(1);
          rem_d       = rem_q - ONE;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INS_KEY;
        end
      end
      S_INS_KEY: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = base_q + cpo_q;
        ram_wdata_o = key_sel;
        count_d     = count_q + ONE;
        cpo_d       = cpo_q + ONE;
        state_d     = S_TRIM;
      end
      S_TRIM: begin
        if (cpo_q != '0) begin
          base_d  = base_q + tr_extra;
          cpo_d   = tr_c1 + ONE;
          count_d = tr_cnt2;
        end
        if (is_rec && !second_q) begin
          second_d = 1'b1;
          state_d  = S_REC;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (moved_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = base_q + (cpo_q - ONE);
          state_d     = S_RES_WAIT;
        end else begin
          rkey_d  = '0;
          state_d = S_FIN;
        end
      end
      S_RES_WAIT: begin
        rkey_d  = ram_rdata_i;
        state_d = S_FIN;
      end
      S_FIN: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
      moved_q  <= 1'b0;
      cpo_q    <= '0;
      count_q  <= '0;
      base_q   <= '0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      moved_q  <= moved_d;
      cpo_q    <= cpo_d;
      count_q  <= count_d;
      base_q   <= base_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    idx_q      <= idx_d;
    pend_log_q <= pend_log_d;
    rkey_q     <= rkey_d;
  end

  assign ready_o  = (state_q == S_IDLE);
  assign rkey_ext = 64'(rkey_q);

  always_comb begin
    result_o.result_present = moved_q;
    result_o.result_key     = rkey_ext[bbfh_pkg::OUT_KEY_W-1:0];
    result_o.can_back       = (cpo_q >= bbfh_pkg::CNT_W'(2));
    result_o.can_forward    = (cpo_q != '0) && (cpo_q < count_q);
    result_o.cursor_pos     = (cpo_q != '0) ? (cpo_q - ONE) : '0;
    result_o.entry_count    = count_q;
  end

  `BBFH_ASSERT_ALWAYS(a_cursor_in_list, clk_i, rst_ni, cpo_q <= count_q, "cursor past list end")
  `BBFH_ASSERT_ALWAYS(a_empty_no_cursor, clk_i, rst_ni, (cpo_q == '0) == (count_q == '0), "cursor and count disagree on empty list")
  `BBFH_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= FULL, "entry count beyond store use")
  `BBFH_ASSERT_IMPLY(a_idle_window, clk_i, rst_ni, (state_q == S_IDLE) && (cpo_q != '0), (9'(cpo_q - ONE) <= SL9) && (9'(count_q - cpo_q) <= SL9), "side limit broken at idle")
  `BBFH_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, state_q == S_INS_KEY, count_q == ($past(count_q) + ONE), "insert did not add one entry")

endmodule

// File: rtl/bounded_back_forward_history.sv
// top level of the bounded back/forward history block
// depends on bbfh_pkg, bbfh_ram and bbfh_engine
//
// s_axis carries one command beat: record, jump (origin then target), back or forward.
// m_axis returns one status beat per command: the entry reached by back or forward,
// the cursor position, the entry count and whether back and forward are possible.
// the history lives in a 128-entry ring ram; cursor, count and ring base are registers.
// an insertion moves every entry after the cursor up by one place, serially through the
// one read port and one write port of the ram; a jump may insert twice. with the default
// side limit of 63 an insertion moves at most 63 entries.
// one command is worked at a time; s_axis_tready is high whenever the sequencer is
// idle, also while a result beat still waits in the output register, so the next
// command can be taken in the cycle after the result beat is loaded.
// when m_axis_tready is low the result beat holds and the sequencer waits after its
// next command until the output register frees up.
// reset empties the history at once; ram contents are not cleared and never read
// before they are written.
module bounded_back_forward_history #(
  parameter int SIDE_LIMIT = bbfh_pkg::SIDE_LIMIT_DEF,
  parameter int KEY_BITS   = bbfh_pkg::KEY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cmd, from_key, from_present, to_key, to_present
  input  logic [bbfh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_present, result_key, can_back, can_forward, cursor_pos, entry_count
  output logic [bbfh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  bbfh_pkg::bbfh_item_t         item;
  bbfh_pkg::bbfh_result_t       eng_res;
  bbfh_pkg::bbfh_result_t       res_q;
  logic                         eng_ready, eng_done, out_free, load;
  logic                         m_valid_q, m_valid_d;
  logic                         ram_we, ram_re;
  logic [bbfh_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0]          ram_wdata, ram_rdata;

  assign item.cmd          = bbfh_pkg::bbfh_cmd_e'(s_axis_tdata[1:0]);
  assign item.from_key     = s_axis_tdata[33:2];
  assign item.from_present = s_axis_tdata[34];
  assign item.to_key       = s_axis_tdata[66:35];
  assign item.to_present   = s_axis_tdata[67];

  assign s_axis_tready = eng_ready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign load          = eng_done && out_free;

  bbfh_engine #(
    .SIDE_LIMIT (SIDE_LIMIT),
    .KEY_BITS   (KEY_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && eng_ready),
    .item_i      (item),
    .ready_o     (eng_ready),
    .done_o      (eng_done),
    .out_free_i  (out_free),
    .result_o    (eng_res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bbfh_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (bbfh_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= eng_res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, res_q.entry_count, res_q.cursor_pos, res_q.can_forward,
                          res_q.can_back, res_q.result_key, res_q.result_present};

endmodule

// File: tb/sv/testbench.sv
// testbench for bounded_back_forward_history: command beats in, one status beat out each
// keeps its own copy of the history list and cursor to predict every status beat
// depends on bbfh_pkg and the rtl of bounded_back_forward_history
`timescale 1ns / 1ps

module testbench;
  import bbfh_pkg::*;

  localparam int SIDE_LIMIT = SIDE_LIMIT_DEF;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic        present;
    logic [31:0] key;
    logic        can_back;
    logic        can_fwd;
    logic [6:0]  pos;
    logic [6:0]  cnt;
  } nav_status_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // history copy
  logic [31:0] hist_keys [0:STORE_DEPTH-1];
  int          hist_cur1;
  int          hist_len;

  nav_status_t status_q [$];
  logic [31:0] key_pool [0:11];
  int          errors;
  int          gap_pct;
  int          stall_pct;
  int          stall_left;
  int          idle_cycles;

  bounded_back_forward_history #(
    .SIDE_LIMIT (SIDE_LIMIT),
    .KEY_BITS   (KEY_BITS_DEF)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // cmd, from_key, from_present, to_key, to_present
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // result_present, result_key, can_back, can_forward, cursor_pos, entry_count
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // drop entries farther than the side limit from the cursor
  function automatic void hist_trim();
    int c;
    int extra;
    int after;
    if (hist_cur1 == 0) return;
    c = hist_cur1 - 1;
    if (c > SIDE_LIMIT) begin
      extra = c - SIDE_LIMIT;
      for (int i = 0; i < hist_len - extra; i++) hist_keys[i] = hist_keys[i + extra];
      hist_len  -= extra;
      hist_cur1 -= extra;
      c         -= extra;
    end
    after = hist_len - c - 1;
    if (after > SIDE_LIMIT) hist_len -= after - SIDE_LIMIT;
  endfunction

  function automatic void hist_record(logic [31:0] key, logic present);
    int c;
    if (!present) return;
    if (hist_cur1 != 0) begin
      c = hist_cur1 - 1;
      if (hist_keys[c] == key) return;
      if (c + 1 < hist_len && hist_keys[c + 1] == key) begin
        hist_cur1++;
        hist_trim();
        return;
      end
    end
    if (hist_len >= STORE_USE) begin
      if (hist_cur1 > 1) begin
        for (int i = 0; i < hist_len - 1; i++) hist_keys[i] = hist_keys[i + 1];
        hist_cur1--;
      end
      hist_len--;
    end
    for (int i = hist_len; i > hist_cur1; i--) hist_keys[i] = hist_keys[i - 1];
    hist_keys[hist_cur1] = key;
    hist_len++;
    hist_cur1++;
    hist_trim();
  endfunction

  function automatic nav_status_t hist_apply(bbfh_cmd_e cmd, logic [31:0] fk, logic fp,
                                             logic [31:0] tk, logic tp);
    nav_status_t st;
    st = '0;
    case (cmd)
      CMD_RECORD: begin
        hist_record(tk, tp);
      end
      CMD_JUMP: begin
        hist_record(fk, fp);
        hist_record(tk, tp);
      end
      CMD_BACK: begin
        if (hist_cur1 >= 2) begin
          hist_cur1--;
          hist_trim();
          st.present = 1'b1;
          st.key     = hist_keys[hist_cur1 - 1];
        end
      end
      default: begin
        if (hist_cur1 != 0 && hist_cur1 < hist_len) begin
          hist_cur1++;
          hist_trim();
          st.present = 1'b1;
          st.key     = hist_keys[hist_cur1 - 1];
        end
      end
    endcase
    st.can_back = (hist_cur1 >= 2);
    st.can_fwd  = (hist_cur1 != 0 && hist_cur1 < hist_len);
    st.pos      = (hist_cur1 != 0) ? 7'(hist_cur1 - 1) : 7'd0;
    st.cnt      = 7'(hist_len);
    return st;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic coin_present();
    return ($urandom_range(0, 9) != 0);
  endfunction

  task automatic send_cmd(bbfh_cmd_e cmd, logic [31:0] fk, logic fp, logic [31:0] tk,
                          logic tp);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? gap_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, tp, tk, fp, fk, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    status_q.push_back(hist_apply(cmd, fk, fp, tk, tp));
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // status beat checker
  always @(posedge clk_i) begin : status_check
    nav_status_t exp_st;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        $error("status beat with no command outstanding: 0x%0h", m_axis_tdata);
        errors++;
      end else begin
        exp_st = status_q.pop_front();
        check_field("result_present", 32'(exp_st.present), 32'(m_axis_tdata[0]));
        check_field("result_key", exp_st.key, m_axis_tdata[32:1]);
        check_field("can_back", 32'(exp_st.can_back), 32'(m_axis_tdata[33]));
        check_field("can_forward", 32'(exp_st.can_fwd), 32'(m_axis_tdata[34]));
        check_field("cursor_pos", 32'(exp_st.pos), 32'(m_axis_tdata[41:35]));
        check_field("entry_count", 32'(exp_st.cnt), 32'(m_axis_tdata[48:42]));
      end
    end
  end

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) stall_left = gap_len();
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_FORWARD, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'hDEAD_BEEF, 1'b0);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'h0000_0000, 1'b1);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'h0000_0000, 1'b1);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'hA5A5_A5A5, 1'b1);
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_FORWARD, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'hA5A5_A5A5, 1'b1);
    send_cmd(CMD_FORWARD, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_RECORD, '0, 1'b0, 32'h1234_5678, 1'b1);
    send_cmd(CMD_JUMP, 32'hFFFF_FFFF, 1'b0, 32'h5A5A_5A5A, 1'b1);
    send_cmd(CMD_JUMP, 32'h0F0F_0F0F, 1'b1, 32'hF0F0_F0F0, 1'b1);
    send_cmd(CMD_JUMP, 32'h1111_1111, 1'b0, 32'h2222_2222, 1'b0);
    send_cmd(CMD_JUMP, 32'h3333_3333, 1'b1, 32'h4444_4444, 1'b0);
    send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    send_cmd(CMD_JUMP, 32'h0F0F_0F0F, 1'b1, 32'hF0F0_F0F0, 1'b1);
    send_cmd(CMD_FORWARD, '0, 1'b0, '0, 1'b0);
  endtask

  // push the cursor past the side limit, walk back, then fill the store to its use limit
  task automatic test_fill_and_trim();
    repeat (70) send_cmd(CMD_RECORD, '0, 1'b0, $urandom, 1'b1);
    repeat (66) send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    repeat (70) send_cmd(CMD_RECORD, '0, 1'b0, $urandom, 1'b1);
    repeat (3) send_cmd(CMD_JUMP, $urandom, 1'b1, $urandom, 1'b1);
    repeat (40) send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
    repeat (45) send_cmd(CMD_FORWARD, '0, 1'b0, '0, 1'b0);
  endtask

  task automatic test_random_walk(int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      len = (r >= 4 && r <= 7) ? $urandom_range(1, 70) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        if (r <= 3) begin
          case ($urandom_range(0, 4))
            0: send_cmd(CMD_RECORD, $urandom, 1'b0, pick_key(), coin_present());
            1: send_cmd(CMD_JUMP, pick_key(), coin_present(), pick_key(), coin_present());
            2: send_cmd(CMD_BACK, $urandom, coin_present(), $urandom, coin_present());
            3: send_cmd(CMD_FORWARD, $urandom, coin_present(), $urandom, coin_present());
            default: send_cmd(CMD_RECORD, '0, 1'b0, $urandom, 1'b1);
          endcase
        end else if (r <= 5) begin
          send_cmd(CMD_RECORD, '0, 1'b0, pick_key(), coin_present());
        end else if (r == 6) begin
          send_cmd(CMD_BACK, '0, 1'b0, '0, 1'b0);
        end else if (r == 7) begin
          send_cmd(CMD_FORWARD, '0, 1'b0, '0, 1'b0);
        end else if (r == 8) begin
          send_cmd(CMD_JUMP, pick_key(), coin_present(), pick_key(), coin_present());
        end else begin
          send_cmd(bbfh_cmd_e'($urandom_range(0, 3)), $urandom, 1'($urandom),
                   $urandom, 1'($urandom));
        end
      end
      sent += len;
    end
  endtask

  task automatic test_noise(int n_items);
    repeat (n_items) begin
      send_cmd(bbfh_cmd_e'($urandom_range(0, 3)), $urandom, 1'($urandom), $urandom,
               1'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    errors        = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    stall_left    = 0;
    idle_cycles   = 0;
    hist_cur1     = 0;
    hist_len      = 0;
    foreach (hist_keys[i]) hist_keys[i] = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = $urandom;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct = 30;
    stall_pct = 30;
    test_directed();
    gap_pct = 0;
    stall_pct = 0;
    test_fill_and_trim();
    gap_pct = 40;
    stall_pct = 40;
    test_random_walk(500);
    gap_pct = 0;
    stall_pct = 0;
    test_random_walk(450);
    gap_pct = 15;
    stall_pct = 60;
    test_random_walk(450);
    gap_pct = 50;
    stall_pct = 10;
    test_noise(150);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (status_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: bounded_back_forward_history.f
+incdir+rtl
rtl/bbfh_pkg.sv
rtl/bbfh_ram.sv
rtl/bbfh_engine.sv
rtl/bounded_back_forward_history.sv
tb/sv/testbench.sv
